// ----- hdl/mgs_pkg.sv -----
// Package for the maze goal search block: cell codes, headings, field widths.
// No dependencies; used by every module under hdl.
package mgs_pkg;
  localparam logic [1:0] CODE_FREE = 2'd0;
  localparam logic [1:0] CODE_WALL = 2'd1;
  localparam logic [1:0] CODE_GOAL = 2'd2;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] HEAD_R = 2'd0;
  localparam logic [1:0] HEAD_D = 2'd1;
  localparam logic [1:0] HEAD_L = 2'd2;
  localparam logic [1:0] HEAD_U = 2'd3;

  localparam logic [1:0] CFG_ROWS   = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_TARGET = 2'd2;

  localparam int CFG_W = 7;

  // Direction to try for a given arrival heading and try number.
  function automatic logic [1:0] try_dir(input logic [1:0] head, input logic [1:0] tries);
    logic [1:0] d;
    d = head;
    case (tries)
      2'd1: d = head + 2'd1;
      2'd2: d = head - 2'd1;
      default: d = head;
    endcase
    return d;
  endfunction
endpackage

// ----- hdl/mgs_walker.sv -----
// Sequencer and stores of the maze goal search: cell, mark and stack memories.
// Depends on mgs_pkg.
module mgs_walker #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 take,
  input  logic [1:0]           kind,
  input  logic [5:0]           row,
  input  logic [5:0]           column,
  input  logic [1:0]           cell_code,
  input  logic [mgs_pkg::CFG_W-1:0] rows_cfg,
  input  logic [mgs_pkg::CFG_W-1:0] cols_cfg,
  input  logic [mgs_pkg::CFG_W-1:0] target_cfg,
  output logic                 busy,
  output logic                 done,
  output logic                 res_found,
  output logic [1:0]           res_code,
  output logic                 res_visited,
  output logic                 res_route
);
  import mgs_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int AW    = RW + CW;
  localparam int CELLS = 1 << AW;
  localparam int SPW   = $clog2(CELLS + 1);
  localparam int DW    = 11;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_FETCH = 11'b00000000100,
    S_TOP   = 11'b00000001000,
    S_PROBE = 11'b00000010000,
    S_CHECK = 11'b00000100000,
    S_ROUTE = 11'b00001000000,
    S_RWAIT = 11'b00010000000,
    S_READ  = 11'b00100000000,
    S_DONE  = 11'b01000000000,
    S_INIT  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic [AW-1:0] cell_idx;
    logic [1:0]    head;
    logic [1:0]    tries;
  } frame_t;

  logic [1:0] cell_mem  [CELLS];
  logic       vis_mem   [CELLS];
  logic       route_mem [CELLS];
  frame_t     stack_mem [CELLS];

  state_t state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [SPW-1:0] k_r, k_nxt;
  logic [AW:0]    clr_r, clr_nxt;
  logic [6:0]     goals_r, goals_nxt;
  logic [RW:0]    cr_r, cr_nxt;
  logic [CW:0]    cc_r, cc_nxt;
  logic [1:0]     chead_r, chead_nxt;
  logic           found_r, found_nxt;
  logic [RW-1:0]  rsel_r;
  logic [CW-1:0]  csel_r;
  logic           rin_r;
  logic [6:0]     rows_lim, cols_lim;

  logic [1:0] code_q;
  logic       vis_q, route_q;
  frame_t     top_q;

  logic [AW-1:0] raddr, waddr_frame, cidx;
  logic          vis_we, vis_wd, route_we, cell_we, st_we;
  logic [AW-1:0] vis_wa, route_wa, cell_wa, st_wa;
  logic [1:0]    cell_wd;
  frame_t        st_wd;
  logic [SPW-1:0] st_ra;
  logic [RW:0]   nr;
  logic [CW:0]   nc;
  logic [1:0]    dir;
  logic          on_grid;

  assign rows_lim = (DW'(rows_cfg) > DW'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_cfg;
  assign cols_lim = (DW'(cols_cfg) > DW'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : cols_cfg;
  assign cidx     = {cr_r[RW-1:0], cc_r[CW-1:0]};
  assign busy     = (state_r != S_IDLE);
  assign done     = (state_r == S_DONE);

  // one write and one read port each; reads registered
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (route_we) route_mem[route_wa] <= (state_r == S_ROUTE);
    if (st_we) stack_mem[st_wa] <= st_wd;
    code_q  <= cell_mem[raddr];
    vis_q   <= vis_mem[raddr];
    route_q <= route_mem[raddr];
    top_q   <= stack_mem[st_ra[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    sp_nxt = sp_r; k_nxt = k_r; clr_nxt = clr_r; goals_nxt = goals_r;
    cr_nxt = cr_r; cc_nxt = cc_r; chead_nxt = chead_r; found_nxt = found_r;
    raddr = cidx; st_ra = (sp_r == '0) ? '0 : sp_r - 1'b1;
    vis_we = 1'b0; vis_wa = cidx; vis_wd = 1'b1;
    route_we = 1'b0; route_wa = cidx;
    cell_we = 1'b0; cell_wa = {RW'(row), CW'(column)};
    cell_wd = (cell_code == 2'd3) ? CODE_WALL : cell_code;
    st_we = 1'b0; st_wa = st_ra[AW-1:0]; st_wd = top_q;
    waddr_frame = top_q.cell_idx;
    dir = try_dir(top_q.head, top_q.tries);
    nr = {1'b0, waddr_frame[AW-1:CW]};
    nc = {1'b0, waddr_frame[CW-1:0]};
    case (dir)
      HEAD_R: nc = nc + 1'b1;
      HEAD_D: nr = nr + 1'b1;
      HEAD_L: nc = nc - 1'b1;
      default: nr = nr - 1'b1;
    endcase
    on_grid = (7'(cr_r) < rows_lim) && (7'(cc_r) < cols_lim);
    unique case (state_r)
      S_INIT: begin
        // drop all marks once after reset, one cell a cycle
        vis_we = 1'b1; vis_wd = 1'b0; vis_wa = clr_r[AW-1:0];
        route_we = 1'b1; route_wa = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (kind)
            KIND_LOAD: begin
              cell_we = (DW'(row) < DW'(MAX_ROWS)) && (DW'(column) < DW'(MAX_COLUMNS));
            end
            KIND_RUN: begin
              clr_nxt = '0; state_nxt = S_CLEAR;
            end
            KIND_READ: state_nxt = S_RWAIT;
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        // drop marks one cell a cycle
        vis_we = 1'b1; vis_wd = 1'b0; vis_wa = clr_r[AW-1:0];
        route_we = 1'b1; route_wa = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(CELLS - 1)) begin
          sp_nxt = '0; goals_nxt = '0; found_nxt = 1'b0;
          cr_nxt = '0; cc_nxt = '0; chead_nxt = HEAD_R;
          state_nxt = S_PROBE;
        end
      end
      S_FETCH: begin
        if (sp_r == '0) begin
          found_nxt = 1'b0; state_nxt = S_DONE;
        end else state_nxt = S_TOP;
      end
      S_TOP: begin
        if (top_q.tries == 2'd3) begin
          sp_nxt = sp_r - 1'b1; state_nxt = S_FETCH;
        end else begin
          st_we = 1'b1; st_wd.tries = top_q.tries + 1'b1;
          cr_nxt = nr; cc_nxt = nc; chead_nxt = dir;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        // wait for cell code and visited mark
        if (!on_grid || cr_r[RW] || cc_r[CW]) state_nxt = (sp_r == '0) ? S_DONE : S_FETCH;
        else state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (code_q == CODE_WALL || vis_q) state_nxt = S_FETCH;
        else begin
          vis_we = 1'b1;
          if (code_q == CODE_GOAL &&
              (goals_r + 7'(goals_r != 7'd127)) == target_cfg) begin
            goals_nxt = goals_r + 1'b1; found_nxt = 1'b1;
            k_nxt = '0; state_nxt = S_ROUTE;
          end else begin
            if (code_q == CODE_GOAL && goals_r != 7'd127) goals_nxt = goals_r + 1'b1;
            if (sp_r != SPW'(CELLS)) begin
              st_we = 1'b1; st_wa = sp_r[AW-1:0];
              st_wd.cell_idx = cidx; st_wd.head = chead_r; st_wd.tries = 2'd0;
              sp_nxt = sp_r + 1'b1;
            end
            state_nxt = S_FETCH;
          end
        end
      end
      S_ROUTE: begin
        // mark path frame by frame: address, then write
        st_ra = k_r;
        if (k_r == sp_r) state_nxt = S_DONE;
        else if (clr_r[0]) begin
          route_we = 1'b1; route_wa = top_q.cell_idx;
          k_nxt = k_r + 1'b1; clr_nxt[0] = 1'b0;
        end else clr_nxt[0] = 1'b1;
      end
      S_RWAIT: begin
        raddr = {rsel_r, csel_r}; state_nxt = S_READ;
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        // hold the result until the output register takes it
        if (take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; sp_r <= '0; goals_r <= '0; found_r <= 1'b0;
      k_r <= '0; clr_r <= '0;
    end else begin
      state_r <= state_nxt; sp_r <= sp_nxt; goals_r <= goals_nxt;
      found_r <= found_nxt; k_r <= k_nxt; clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r <= cr_nxt; cc_r <= cc_nxt; chead_r <= chead_nxt;
    if (state_r == S_IDLE && start) begin
      rsel_r <= RW'(row); csel_r <= CW'(column);
      rin_r  <= (DW'(row) < DW'(MAX_ROWS)) && (DW'(column) < DW'(MAX_COLUMNS));
    end
  end

  // hold result fields; run gives found, read gives code and marks
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      res_found <= 1'b0;
      res_code <= rin_r ? code_q : 2'd0;
      res_visited <= rin_r & vis_q;
      res_route <= rin_r & route_q;
    end else if (state_nxt == S_DONE && state_r != S_DONE) begin
      res_found <= found_nxt; res_code <= '0; res_visited <= 1'b0; res_route <= 1'b0;
    end
  end
endmodule

// ----- hdl/maze_goal_search_dfs.sv -----
// Top level of the maze goal search: handshakes, configuration, output register.
// Depends on mgs_pkg and mgs_walker.
//
// After reset the block clears all visited and route marks, one cell a cycle,
// with in_ready low. A load leaves the block idle, so loads can follow back to
// back. A read passes the read-wait, read and done states before the block can
// take the next request. A run first clears all marks again, then walks: a
// probe of a cell passes the probe state, and the check state too when the cell
// is on the grid; the next probe or a backtrack reads the stack memory in the
// fetch and top states. When the target goal is found, the run marks the route
// frame by frame. The block takes one request at a time and holds in_ready
// low while it works; a finished result moves into the output register, so
// loads go on while a result waits, and a later result holds the block until
// the output register is free.
module maze_goal_search_dfs #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_row,
  input  logic [5:0] in_column,
  input  logic [1:0] in_cell_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_search_found,
  output logic [1:0] out_read_code,
  output logic       out_read_visited,
  output logic       out_read_on_route,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import mgs_pkg::*;

  logic [CFG_W-1:0] rows_r, cols_r, target_r;
  logic busy, done, f, v, rt;
  logic [1:0] c;
  logic start, take;
  logic found_r, visited_r, route_r;
  logic [1:0] code_r;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  // advance a finished result when the output register is free or being taken
  assign take     = done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd1; cols_r <= 7'd1; target_r <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS:   rows_r <= cfg_data;
        CFG_COLS:   cols_r <= cfg_data;
        CFG_TARGET: target_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mgs_walker #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_walk (
    .clk, .rst_n, .start, .take, .kind(in_kind), .row(in_row), .column(in_column),
    .cell_code(in_cell_code), .rows_cfg(rows_r), .cols_cfg(cols_r),
    .target_cfg(target_r), .busy, .done, .res_found(f), .res_code(c),
    .res_visited(v), .res_route(rt)
  );

  // hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (take) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found_r <= f; code_r <= c; visited_r <= v; route_r <= rt;
    end
  end

  assign out_search_found  = found_r;
  assign out_read_code     = code_r;
  assign out_read_visited  = visited_r;
  assign out_read_on_route = route_r;
endmodule
